/* rtl/tslne_pkg.sv */
// ============================================================================
// tslne_pkg
// Shared constants for the text stream line-number and escape filter:
// character codes, numbering modes, configuration register indexes and item kinds.
// ============================================================================
`default_nettype none

package tslne_pkg;

    // Character codes used by the filter.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [6:0] LOW_DEL   = 7'h7F;
    localparam logic [7:0] CARET_OFS = 8'h40;

    // Numbering modes.
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

    // Input item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

endpackage

`default_nettype wire

/* rtl/text_stream_line_number_escape_top.sv */
// The first result beat of an item passes the drain stage registers, then the output register.
// An item that yields N result beats holds the drain stage until all have drained, so plain
// bytes flow at one item per cycle while the output is not stalled; a numbered line start adds
// NUMBER_DIGITS + 1 prefix beats. Items that yield no result do not occupy the drain stage.
// Reset (synchronous, active low) clears all options, starts at a line start and sets the
// line count to one.
// ============================================================================
// text_stream_line_number_escape_top
// Byte stream filter: optional line numbers, blank-line squeezing, end marks
// and caret / meta escapes. Each accepted item is expanded into a short list
// of result bytes that drains one beat per cycle when not stalled, via an output register.
// ============================================================================
`default_nettype none

module text_stream_line_number_escape_top
    import tslne_pkg::*;
#(
    parameter int unsigned NUMBER_DIGITS = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_kind,
    input  wire logic [7:0]           i_data_byte,
    // Output channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_out_byte,
    output logic                      o_last
);

    localparam int unsigned CNT_W     = NUMBER_DIGITS * 4;
    localparam int unsigned PRE_LEN   = NUMBER_DIGITS + 1;
    localparam int unsigned POS_W     = $clog2(NUMBER_DIGITS + 6);
    localparam int unsigned PRE_IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    // Configuration registers.
    logic [1:0] r_number_mode;
    logic       r_squeeze_blank;
    logic       r_show_ends;
    logic       r_show_tabs;
    logic       r_show_nonprinting;

    // Per-stream state.
    logic             r_after_nl, n_after_nl;
    logic [1:0]       r_blank_run, n_blank_run;
    logic [CNT_W-1:0] r_count, n_count;

    // Drain stage: the result list of the item at work.
    logic             r_busy, n_busy;
    logic             r_num, n_num;
    logic [7:0]       r_pre [NUMBER_DIGITS];
    logic [7:0]       n_pre [NUMBER_DIGITS];
    logic [7:0]       r_chr [4];
    logic [7:0]       n_chr [4];
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_end, n_end;

    // Output register.
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;

    logic                 accept;
    logic                 advance;
    logic                 final_beat;
    logic [2:0]           n_nchr;
    logic [POS_W-1:0]     chr_pos;
    logic [PRE_IDX_W-1:0] pre_idx;
    logic [7:0]           cur_byte;
    logic                 seen;
    logic                 all_nine;
    logic                 carry;
    logic                 skip;
    logic [3:0]           dig;
    logic [6:0]           low7;

    // Handshake control.
    assign advance    = r_busy && (!r_ovalid || i_out_ready);
    assign final_beat = (r_pos == r_end);
    assign o_in_ready = !r_busy || (advance && final_beat);
    assign accept     = i_in_valid && o_in_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_mode      <= '0;
            r_squeeze_blank    <= 1'b0;
            r_show_ends        <= 1'b0;
            r_show_tabs        <= 1'b0;
            r_show_nonprinting <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUMBER_MODE:      r_number_mode      <= i_cfg_data;
                REG_SQUEEZE_BLANK:    r_squeeze_blank    <= i_cfg_data[0];
                REG_SHOW_ENDS:        r_show_ends        <= i_cfg_data[0];
                REG_SHOW_TABS:        r_show_tabs        <= i_cfg_data[0];
                REG_SHOW_NONPRINTING: r_show_nonprinting <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Build the result list of an incoming item and the next stream state.
    always_comb begin
        n_after_nl  = r_after_nl;
        n_blank_run = r_blank_run;
        n_count     = r_count;
        n_num       = 1'b0;
        n_nchr      = 3'd0;
        skip        = 1'b0;
        seen        = 1'b0;
        all_nine    = 1'b1;
        carry       = 1'b1;
        dig         = '0;
        low7        = i_data_byte[6:0];
        for (int k = 0; k < 4; k++) begin
            n_chr[k] = i_data_byte;
        end

        // Prefix digits with leading zeros shown as spaces.
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            dig = r_count[i*4 +: 4];
            if (dig > 4'd9) begin
                dig = 4'd9;
            end
            if (dig != 4'd0 || i == 0) begin
                seen = 1'b1;
            end
            n_pre[i] = seen ? (CH_ZERO + {4'd0, dig}) : CH_SPACE;
        end

        // Saturating BCD increment.
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (r_count[i*4 +: 4] != 4'd9) begin
                all_nine = 1'b0;
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (r_count[i*4 +: 4] >= 4'd9) begin
                    n_count[i*4 +: 4] = 4'd0;
                end else begin
                    n_count[i*4 +: 4] = r_count[i*4 +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nine) begin
            n_count = r_count;
        end

        if (i_kind == KIND_EOF) begin
            // End of file closes an unterminated line.
            if (r_show_ends && !r_after_nl) begin
                n_chr[0] = CH_DOLLAR;
                n_nchr   = 3'd1;
            end
            n_count     = r_count;
            n_after_nl  = 1'b1;
            n_blank_run = 2'd0;
        end else begin
            // Blank-line squeezing.
            if (r_squeeze_blank && r_after_nl && i_data_byte == CH_NL) begin
                if (r_blank_run != 2'd3) begin
                    n_blank_run = r_blank_run + 2'd1;
                end
                skip = (n_blank_run > 2'd1);
            end else begin
                n_blank_run = 2'd0;
            end

            if (skip) begin
                n_count = r_count;
            end else begin
                n_num = r_after_nl && ((r_number_mode == NUM_ALL) ||
                        (r_number_mode == NUM_NONBLANK && i_data_byte != CH_NL));
                if (!n_num) begin
                    n_count = r_count;
                end

                // Character or its escape.
                if (i_data_byte == CH_NL) begin
                    if (r_show_ends) begin
                        n_chr[0] = CH_DOLLAR;
                        n_chr[1] = CH_NL;
                        n_nchr   = 3'd2;
                    end else begin
                        n_nchr   = 3'd1;
                    end
                end else if (i_data_byte == CH_TAB && r_show_tabs) begin
                    n_chr[0] = CH_CARET;
                    n_chr[1] = CH_I;
                    n_nchr   = 3'd2;
                end else if (i_data_byte == CH_DEL) begin
                    n_chr[0] = CH_CARET;
                    n_chr[1] = CH_QUEST;
                    n_nchr   = 3'd2;
                end else if (r_show_nonprinting && i_data_byte[7]) begin
                    n_chr[0] = CH_M;
                    n_chr[1] = CH_DASH;
                    if (low7 == LOW_DEL) begin
                        n_chr[2] = CH_CARET;
                        n_chr[3] = CH_QUEST;
                        n_nchr   = 3'd4;
                    end else if (low7 < 7'd32) begin
                        n_chr[2] = CH_CARET;
                        n_chr[3] = {1'b0, low7} + CARET_OFS;
                        n_nchr   = 3'd4;
                    end else begin
                        n_chr[2] = {1'b0, low7};
                        n_nchr   = 3'd3;
                    end
                end else if (r_show_nonprinting && i_data_byte < 8'd32
                             && i_data_byte != CH_TAB) begin
                    n_chr[0] = CH_CARET;
                    n_chr[1] = i_data_byte + CARET_OFS;
                    n_nchr   = 3'd2;
                end else begin
                    n_nchr   = 3'd1;
                end
                n_after_nl = (i_data_byte == CH_NL);
            end
        end

        n_busy = n_num || (n_nchr != 3'd0);
        n_end  = (n_num ? POS_W'(PRE_LEN) : POS_W'(0)) + POS_W'(n_nchr) - POS_W'(1);
    end

    // Pick the byte at the current position of the result list.
    always_comb begin
        chr_pos = r_num ? (r_pos - POS_W'(PRE_LEN)) : r_pos;
        pre_idx = PRE_IDX_W'(POS_W'(NUMBER_DIGITS - 1) - r_pos);
        if (r_num && r_pos < POS_W'(NUMBER_DIGITS)) begin
            cur_byte = r_pre[pre_idx];
        end else if (r_num && r_pos == POS_W'(NUMBER_DIGITS)) begin
            cur_byte = CH_TAB;
        end else begin
            cur_byte = r_chr[chr_pos[1:0]];
        end
    end

    // Stream state and drain stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_nl  <= 1'b1;
            r_blank_run <= 2'd0;
            r_count     <= CNT_W'(1);
            r_busy      <= 1'b0;
            r_pos       <= '0;
        end else if (accept) begin
            r_after_nl  <= n_after_nl;
            r_blank_run <= n_blank_run;
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_pos       <= '0;
        end else if (advance) begin
            if (final_beat) begin
                r_busy <= 1'b0;
            end
            r_pos <= r_pos + POS_W'(1);
        end
    end

    // Result list payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_num <= n_num;
            r_end <= n_end;
            r_pre <= n_pre;
            r_chr <= n_chr;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (advance) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_obyte <= cur_byte;
            r_olast <= final_beat;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last      = r_olast;

endmodule

`default_nettype wire
